// ----- hw/rtl/mssd_pkg.sv -----
// ----------------------------------------------------------------------------
// mssd_pkg: shared types and constants of the Morse symbol stream decoder
// Payload structs, symbol and register codes, and the A..Z letter table.
// ----------------------------------------------------------------------------
package mssd_pkg;

  // Default for the number of dots/dashes collected per letter (4..6)
  localparam int unsigned MAX_ELEMENTS_DEF = 4;

  localparam int unsigned ZeroRunW   = 4;
  localparam logic [ZeroRunW-1:0] ZERO_RUN_MAX = 4'd15;

  localparam int unsigned LetterGapW = 3;
  localparam int unsigned WordGapW   = 4;
  localparam logic [LetterGapW-1:0] LETTER_GAP_RST = 3'd3;
  localparam logic [WordGapW-1:0]   WORD_GAP_RST   = 4'd7;

  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned CfgDataW  = 8;
  localparam logic [CfgIndexW-1:0] CFG_LETTER_GAP = 4'd0;
  localparam logic [CfgIndexW-1:0] CFG_WORD_GAP   = 4'd1;

  localparam logic [1:0] SYM_GAP = 2'd0;

  localparam logic [6:0] CHAR_NONE  = 7'd0;
  localparam logic [6:0] CHAR_SPACE = 7'd32;

  typedef struct packed {
    logic [1:0] symbol;
    logic       last;
  } sym_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       error;
    logic       end_of_message;
  } res_t;

  localparam logic [6:0] LEN2_TAB [4] = '{7'h49, 7'h4E, 7'h41, 7'h4D};  // I N A M
  localparam logic [6:0] LEN3_TAB [8] = '{7'h53, 7'h44, 7'h52, 7'h47,   // S D R G
                                          7'h55, 7'h4B, 7'h57, 7'h4F};  // U K W O
  localparam logic [6:0] LEN4_TAB [16] = '{7'h48, 7'h42, 7'h4C, 7'h5A,  // H B L Z
                                           7'h46, 7'h43, 7'h50, 7'h00,  // F C P -
                                           7'h56, 7'h58, 7'h00, 7'h51,  // V X - Q
                                           7'h00, 7'h59, 7'h4A, 7'h00}; // - Y J -

  // Pattern bit i is element i, 1 = dash. Zero means no letter.
  function automatic logic [6:0] lookup_letter(input logic [2:0] len,
                                               input logic [3:0] pat);
    logic [6:0] ch;
    ch = CHAR_NONE;
    unique case (len)
      3'd1:    ch = pat[0] ? 7'h54 : 7'h45;  // T / E
      3'd2:    ch = LEN2_TAB[pat[1:0]];
      3'd3:    ch = LEN3_TAB[pat[2:0]];
      3'd4:    ch = LEN4_TAB[pat];
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ----- hw/rtl/morse_symbol_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// morse_symbol_stream_decoder_top: Morse symbol stream decoder
// Turns a stream of gap/dot/dash symbols into letters, spaces and errors.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (symbol, last)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (char_code, error,
//          |           |                         |             end_of_message)
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One symbol per cycle sustained unless a full result register stalls. A
//  symbol is held in the input register until the decode step takes it,
//  decoded in a single step against the pattern/gap-run state, and its result
//  (if any) is loaded into the result register when that step happens.
//  A symbol that produces no result still moves through the input register,
//  so a stalled consumer only blocks symbols that would produce a result.
//  Reset clears all decode state and sets letter gap = 3, word gap = 7.
//  Configuration transactions are always accepted and take effect once registered.
//
module morse_symbol_stream_decoder_top #(
  parameter int unsigned MaxElements = mssd_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mssd_pkg::sym_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mssd_pkg::res_t                   out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mssd_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [mssd_pkg::CfgDataW-1:0]    cfg_data_i
);

  // configuration registers
  logic [mssd_pkg::LetterGapW-1:0] letter_gap_q, letter_gap_d;
  logic [mssd_pkg::WordGapW-1:0]   word_gap_q, word_gap_d;

  // input register to decode step
  logic           sym_valid;
  mssd_pkg::sym_t sym_data;
  logic           step;
  logic           emit;
  mssd_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    letter_gap_d = letter_gap_q;
    word_gap_d   = word_gap_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == mssd_pkg::CFG_LETTER_GAP) begin
        letter_gap_d = cfg_data_i[mssd_pkg::LetterGapW-1:0];
      end else if (cfg_index_i == mssd_pkg::CFG_WORD_GAP) begin
        word_gap_d = cfg_data_i[mssd_pkg::WordGapW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_gap_q <= mssd_pkg::LETTER_GAP_RST;
      word_gap_q   <= mssd_pkg::WORD_GAP_RST;
    end else begin
      letter_gap_q <= letter_gap_d;
      word_gap_q   <= word_gap_d;
    end
  end

  // The held symbol moves on unless it has a result and the result
  // register is full and not being drained this cycle.
  assign step = sym_valid && (!emit || !out_valid_o || out_ready_i);

  mssd_sym_reg u_sym_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .step_i     (step),
    .valid_o    (sym_valid),
    .data_o     (sym_data)
  );

  mssd_core #(
    .MaxElements (MaxElements)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .sym_i        (sym_data),
    .letter_gap_i (letter_gap_q),
    .word_gap_i   (word_gap_q),
    .emit_o       (emit),
    .res_o        (res)
  );

  mssd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && emit),
    .data_i      (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/mssd_sym_reg.sv -----
// ----------------------------------------------------------------------------
// mssd_sym_reg: input register
// Holds one accepted symbol until the decode step consumes it.
// ----------------------------------------------------------------------------
module mssd_sym_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mssd_pkg::sym_t  in_data_i,
  input  logic            step_i,
  output logic            valid_o,
  output mssd_pkg::sym_t  data_o
);

  logic           valid_q, valid_d;
  mssd_pkg::sym_t data_q;
  logic           load;

  assign in_ready_o = !valid_q || step_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (step_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/mssd_core.sv -----
// ----------------------------------------------------------------------------
// mssd_core: decode state and single-step update
// Collects elements, counts the gap run, looks up letters and forms results.
// ----------------------------------------------------------------------------
module mssd_core #(
  parameter int unsigned MaxElements = mssd_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  mssd_pkg::sym_t                       sym_i,
  input  logic [mssd_pkg::LetterGapW-1:0]      letter_gap_i,
  input  logic [mssd_pkg::WordGapW-1:0]        word_gap_i,
  output logic                                 emit_o,
  output mssd_pkg::res_t                       res_o
);

  localparam int unsigned LenW = $clog2(MaxElements + 1);
  localparam int unsigned IdxW = $clog2(MaxElements);

  logic [MaxElements-1:0]         pattern_q, pattern_d;
  logic [LenW-1:0]                length_q, length_d;
  logic                           too_long_q, too_long_d;
  logic [mssd_pkg::ZeroRunW-1:0]  zero_run_q, zero_run_d;
  logic                           error_seen_q, error_seen_d;

  // after the element/gap update, before any clearing
  logic [MaxElements-1:0]         pat_upd;
  logic [LenW-1:0]                len_upd;
  logic                           tl_upd;
  logic [mssd_pkg::ZeroRunW-1:0]  zr_inc;
  logic [2:0]                     len_lut;
  logic [6:0]                     letter;
  logic [6:0]                     ch;
  logic                           have;

  always_comb begin
    pat_upd = pattern_q;
    len_upd = length_q;
    tl_upd  = too_long_q;
    if (sym_i.symbol != mssd_pkg::SYM_GAP) begin
      if (length_q < LenW'(MaxElements)) begin
        // bit 1 set: dash (code three counts as a dash too)
        pat_upd[length_q[IdxW-1:0]] = sym_i.symbol[1];
        len_upd = length_q + LenW'(1);
      end else begin
        tl_upd = 1'b1;
      end
    end
  end

  assign len_lut = (len_upd <= LenW'(4)) ? len_upd[2:0] : 3'd0;
  assign letter  = tl_upd ? mssd_pkg::CHAR_NONE
                          : mssd_pkg::lookup_letter(len_lut, pat_upd[3:0]);
  assign zr_inc  = zero_run_q + mssd_pkg::ZeroRunW'(1);

  always_comb begin
    pattern_d    = pat_upd;
    length_d     = len_upd;
    too_long_d   = tl_upd;
    zero_run_d   = zero_run_q;
    error_seen_d = error_seen_q;
    have         = 1'b0;
    ch           = mssd_pkg::CHAR_NONE;

    if (error_seen_q) begin
      pattern_d  = pattern_q;
      length_d   = length_q;
      too_long_d = too_long_q;
      have       = sym_i.last;
    end else begin
      if (sym_i.symbol != mssd_pkg::SYM_GAP) begin
        zero_run_d = '0;
      end else if (zero_run_q != mssd_pkg::ZERO_RUN_MAX) begin
        zero_run_d = zr_inc;
        if (zr_inc == mssd_pkg::ZeroRunW'(letter_gap_i)) begin
          ch         = letter;
          have       = 1'b1;
          pattern_d  = '0;
          length_d   = '0;
          too_long_d = 1'b0;
        end else if (zr_inc == word_gap_i) begin
          ch   = mssd_pkg::CHAR_SPACE;
          have = 1'b1;
        end
      end
      if (sym_i.last && !have) begin
        ch   = letter;
        have = 1'b1;
      end
      if (have && !sym_i.last && (ch == mssd_pkg::CHAR_NONE)) begin
        error_seen_d = 1'b1;
      end
    end

    // end of message: back to a clean slate
    if (sym_i.last) begin
      pattern_d    = '0;
      length_d     = '0;
      too_long_d   = 1'b0;
      zero_run_d   = '0;
      error_seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q    <= '0;
      length_q     <= '0;
      too_long_q   <= 1'b0;
      zero_run_q   <= '0;
      error_seen_q <= 1'b0;
    end else if (step_i) begin
      pattern_q    <= pattern_d;
      length_q     <= length_d;
      too_long_q   <= too_long_d;
      zero_run_q   <= zero_run_d;
      error_seen_q <= error_seen_d;
    end
  end

  assign emit_o               = have;
  assign res_o.char_code      = ch;
  assign res_o.error          = (ch == mssd_pkg::CHAR_NONE);
  assign res_o.end_of_message = sym_i.last;

  // an error is only latched at a letter gap, which empties the pattern
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_seen_q |-> (length_q == '0) && !too_long_q)
    else $error("error flag set with a pending pattern");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= LenW'(MaxElements))
    else $error("element count beyond maximum");

  a_too_long_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    too_long_q |-> (length_q == LenW'(MaxElements)))
    else $error("overflow flag without a full pattern");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && sym_i.last) |=> (zero_run_q == '0) && !error_seen_q)
    else $error("state not cleared after last symbol");

endmodule

// ----- hw/rtl/mssd_out_reg.sv -----
// ----------------------------------------------------------------------------
// mssd_out_reg: result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module mssd_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  mssd_pkg::res_t  data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mssd_pkg::res_t  out_data_o
);

  logic           valid_q, valid_d;
  mssd_pkg::res_t data_q;

  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
